### rtl/nbfc_pkg.sv
`timescale 1ns / 1ps

package nbfc_pkg;

	localparam int ADDR_BITS_DEF = 16;

	localparam logic [7:0] FMT_REQ = 8'hB0;
	localparam logic [7:0] FMT_RSP = 8'hB1;

	localparam logic [2:0] REQ_LAST = 3'd5;

	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_BYTE    = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	localparam logic [2:0] KIND_TX   = 3'd0;
	localparam logic [2:0] KIND_CON  = 3'd1;
	localparam logic [2:0] KIND_MEM  = 3'd2;
	localparam logic [2:0] KIND_DONE = 3'd3;
	localparam logic [2:0] KIND_FAIL = 3'd4;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_TIMEOUT = 3'd1;
	localparam logic [2:0] ERR_SUM     = 3'd2;
	localparam logic [2:0] ERR_FORMAT  = 3'd3;
	localparam logic [2:0] ERR_NAK     = 3'd4;
	localparam logic [2:0] ERR_FUNC    = 3'd5;

	localparam logic [7:0] FN_NAK   = 8'd0;
	localparam logic [7:0] FN_PRINT = 8'd1;
	localparam logic [7:0] FN_ADDR  = 8'd2;
	localparam logic [7:0] FN_LOAD  = 8'd3;
	localparam logic [7:0] FN_ENTRY = 8'd4;

	localparam logic [2:0] HDR_FORMAT = 3'd0;
	localparam logic [2:0] HDR_FUNC   = 3'd3;
	localparam logic [2:0] HDR_SIZE   = 3'd4;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_HEADER  = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_CHECK   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] address;
		logic [2:0]  error_code;
		logic        last;
	} result_t;

endpackage

### rtl/network_boot_frame_client.sv
`timescale 1ns / 1ps

// Boot client for a framed byte link. Each accepted item is decoded in the cycle it is
// accepted and its results land in an output register: a start event or a good frame of
// function 1 to 3 produces a six-beat request burst, other events at most one beat. An item
// is taken every cycle while the output register is empty or its final beat is taken, so
// other items flow at one per cycle with result_ready high, and a request burst holds the
// input for six output beats. The load address is ADDR_BITS wide and reported in 16 bits.
module network_boot_frame_client
	import nbfc_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       slave_id_we,
	input  logic [7:0] slave_id_wdata,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result
);

	phase_t                phase_q, phase_d;
	logic [2:0]            hidx_q, hidx_d;
	logic [7:0]            rem_q, rem_d;
	logic [1:0]            pidx_q, pidx_d;
	logic [7:0]            sum_q, sum_d;
	logic                  fmt_ok_q, fmt_ok_d;
	logic [7:0]            func_q, func_d;
	logic [15:0]           arg_q, arg_d;
	logic [ADDR_BITS-1:0]  load_q, load_d;
	logic [7:0]            slave_id_q;

	logic                  pend_q;
	logic                  req_q;
	logic [2:0]            idx_q;
	result_t               res_q;

	logic                  item_fire;
	logic                  result_fire;
	logic                  drain_done;
	logic                  emit;
	logic                  emit_req;
	result_t               res_d;
	logic [7:0]            sum_n;
	logic [7:0]            req_csum;

	logic [ADDR_BITS+15:0] load_ext;
	logic [ADDR_BITS+15:0] arg_ext;
	logic [ADDR_BITS-1:0]  arg_addr;
	logic [ADDR_BITS+15:0] entry_ext;

	assign load_ext  = {16'b0, load_q};
	assign arg_ext   = {{ADDR_BITS{1'b0}}, arg_q};
	assign arg_addr  = arg_ext[ADDR_BITS-1:0];
	assign entry_ext = {16'b0, arg_addr};

	assign sum_n    = sum_q + item.rx_byte;
	assign req_csum = 8'h00 - (FMT_REQ + slave_id_q);

	assign result_valid = pend_q;
	assign result_fire  = result_valid && result_ready;
	assign drain_done   = result_fire && (!req_q || idx_q == REQ_LAST);
	assign item_ready   = !pend_q || drain_done;
	assign item_fire    = item_valid && item_ready;

	always_comb begin
		result = res_q;
		if (req_q) begin
			result.kind       = KIND_TX;
			result.address    = '0;
			result.error_code = ERR_NONE;
			result.last       = (idx_q == REQ_LAST);
			unique case (idx_q)
				3'd0:    result.data_byte = FMT_REQ;
				3'd2:    result.data_byte = slave_id_q;
				REQ_LAST: result.data_byte = req_csum;
				default: result.data_byte = 8'h00;
			endcase
		end
	end

	always_comb begin
		phase_d  = phase_q;
		hidx_d   = hidx_q;
		rem_d    = rem_q;
		pidx_d   = pidx_q;
		sum_d    = sum_q;
		fmt_ok_d = fmt_ok_q;
		func_d   = func_q;
		arg_d    = arg_q;
		load_d   = load_q;
		emit     = 1'b0;
		emit_req = 1'b0;
		res_d    = '{kind: KIND_FAIL, data_byte: 8'h00, address: 16'h0000,
			error_code: ERR_NONE, last: 1'b1};

		if (item_fire) begin
			case (item.opcode)
				OP_START: begin
					load_d   = '0;
					emit_req = 1'b1;
				end
				OP_TIMEOUT: begin
					if (phase_q != PH_IDLE) begin
						emit             = 1'b1;
						res_d.error_code = ERR_TIMEOUT;
						phase_d          = PH_IDLE;
					end
				end
				OP_BYTE: begin
					if (phase_q != PH_IDLE) begin
						sum_d = sum_n;
						unique case (phase_q)
							PH_HEADER: begin
								if (hidx_q == HDR_FORMAT) begin
									fmt_ok_d = (item.rx_byte == FMT_RSP);
								end
								if (hidx_q == HDR_FUNC) begin
									func_d = item.rx_byte;
								end
								if (hidx_q == HDR_SIZE) begin
									rem_d   = item.rx_byte;
									hidx_d  = '0;
									pidx_d  = '0;
									phase_d = (item.rx_byte != 8'd0) ? PH_PAYLOAD : PH_CHECK;
								end else begin
									hidx_d = hidx_q + 3'd1;
								end
							end
							PH_PAYLOAD: begin
								if (pidx_q == 2'd0) begin
									arg_d[7:0] = item.rx_byte;
								end
								if (pidx_q == 2'd1) begin
									arg_d[15:8] = item.rx_byte;
								end
								if (fmt_ok_q && func_q == FN_PRINT) begin
									emit            = 1'b1;
									res_d.kind      = KIND_CON;
									res_d.data_byte = item.rx_byte;
								end
								if (fmt_ok_q && func_q == FN_LOAD) begin
									emit            = 1'b1;
									res_d.kind      = KIND_MEM;
									res_d.data_byte = item.rx_byte;
									res_d.address   = load_ext[15:0];
									load_d = load_q + {{(ADDR_BITS-1){1'b0}}, 1'b1};
								end
								if (pidx_q != 2'd2) begin
									pidx_d = pidx_q + 2'd1;
								end
								rem_d = rem_q - 8'd1;
								if (rem_q == 8'd1) begin
									phase_d = PH_CHECK;
								end
							end
							PH_CHECK: begin
								if (sum_n != 8'd0) begin
									emit             = 1'b1;
									res_d.error_code = ERR_SUM;
									phase_d          = PH_IDLE;
								end else if (!fmt_ok_q) begin
									emit             = 1'b1;
									res_d.error_code = ERR_FORMAT;
									phase_d          = PH_IDLE;
								end else if (func_q == FN_NAK) begin
									emit             = 1'b1;
									res_d.error_code = ERR_NAK;
									phase_d          = PH_IDLE;
								end else if (func_q > FN_ENTRY) begin
									emit             = 1'b1;
									res_d.error_code = ERR_FUNC;
									phase_d          = PH_IDLE;
								end else if (func_q == FN_ENTRY) begin
									emit          = 1'b1;
									res_d.kind    = KIND_DONE;
									res_d.address = entry_ext[15:0];
									phase_d       = PH_IDLE;
								end else begin
									if (func_q == FN_ADDR) begin
										load_d = arg_addr;
									end
									emit_req = 1'b1;
								end
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end

		if (emit_req) begin
			phase_d  = PH_HEADER;
			hidx_d   = '0;
			rem_d    = '0;
			pidx_d   = '0;
			sum_d    = '0;
			fmt_ok_d = 1'b0;
			func_d   = '0;
			arg_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			hidx_q     <= '0;
			rem_q      <= '0;
			pidx_q     <= '0;
			sum_q      <= '0;
			fmt_ok_q   <= 1'b0;
			func_q     <= '0;
			arg_q      <= '0;
			load_q     <= '0;
			slave_id_q <= 8'h70;
			pend_q     <= 1'b0;
			req_q      <= 1'b0;
			idx_q      <= '0;
		end else begin
			phase_q  <= phase_d;
			hidx_q   <= hidx_d;
			rem_q    <= rem_d;
			pidx_q   <= pidx_d;
			sum_q    <= sum_d;
			fmt_ok_q <= fmt_ok_d;
			func_q   <= func_d;
			arg_q    <= arg_d;
			load_q   <= load_d;
			if (slave_id_we) begin
				slave_id_q <= slave_id_wdata;
			end
			if (emit || emit_req) begin
				pend_q <= 1'b1;
				req_q  <= emit_req;
				idx_q  <= '0;
			end else if (drain_done) begin
				pend_q <= 1'b0;
				req_q  <= 1'b0;
				idx_q  <= '0;
			end else if (result_fire) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

endmodule

### rtl/nbfc_checker.sv
`timescale 1ns / 1ps

module nbfc_checker
	import nbfc_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input item_t   item,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// A stalled result beat must hold its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// A start event opens a request frame on the very next cycle.
	a_start_request: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.opcode == OP_START |=>
		result_valid && result.kind == KIND_TX && result.data_byte == FMT_REQ)
		else $error("start did not open a request frame");

	// Only a failure carries an error code.
	a_error_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_FAIL |-> result.error_code == ERR_NONE)
		else $error("error code on a non-failure beat");

	// Verdict beats always close the results of their item.
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_FAIL || result.kind == KIND_DONE) |->
		result.last)
		else $error("verdict beat not marked last");

endmodule

bind network_boot_frame_client nbfc_checker u_nbfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

### sim/tb_network_boot_frame_client.sv
`timescale 1ns / 1ps

module tb_network_boot_frame_client;
	import nbfc_pkg::*;

	localparam int ADDR_BITS = ADDR_BITS_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam result_t NO_BEAT = '0;
	localparam int DIR_ROWS = 28;
	localparam int PHASE_ITEMS = 120;

	localparam int RX_FREE = 0;
	localparam int RX_COIN = 1;
	localparam int RX_PERIODIC = 2;
	localparam int RX_SPARSE = 3;

	typedef struct packed {
		item_t   it;
		logic    typed;
		result_t want;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    slave_id_we;
	logic    [7:0] slave_id_wdata;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	result_t expected_beats[$];
	int      mismatch_count = 0;
	int      live_items = 0;
	int      burst_left = 0;
	bit      hold_off_req = 1'b0;

	// Shadow copy of the client state.
	logic [7:0]           bc_slave_id = 8'h70;
	phase_t               bc_phase = PH_IDLE;
	logic [2:0]           hdr_pos = '0;
	logic [7:0]           pay_left = '0;
	logic [7:0]           pay_pos = '0;
	logic [7:0]           frame_sum = '0;
	logic [7:0]           fmt_seen = '0;
	logic [7:0]           func_seen = '0;
	logic [15:0]          arg_word = '0;
	logic [ADDR_BITS-1:0] load_addr = '0;

	// The fn2 frame leaves the high argument byte missing; the fn3 frame writes across 0x0100.
	stim_row_t dir_rows [DIR_ROWS] = '{
		{OP_BYTE, 8'hFF, 1'b0, NO_BEAT},
		{OP_UNUSED, 8'hFF, 1'b0, NO_BEAT},
		{OP_START, 8'h00, 1'b0, NO_BEAT},
		{OP_TIMEOUT, 8'hFF, 1'b1, KIND_FAIL, 8'h00, 16'h0000, ERR_TIMEOUT, 1'b1},
		{OP_TIMEOUT, 8'h00, 1'b0, NO_BEAT},
		{OP_START, 8'hFF, 1'b0, NO_BEAT},
		{OP_BYTE, FMT_RSP, 1'b0, NO_BEAT},
		{OP_BYTE, 8'hFF, 1'b0, NO_BEAT},
		{OP_BYTE, 8'hFF, 1'b0, NO_BEAT},
		{OP_BYTE, FN_ADDR, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h01, 1'b0, NO_BEAT},
		{OP_BYTE, 8'hFF, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h4F, 1'b0, NO_BEAT},
		{OP_BYTE, FMT_RSP, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
		{OP_BYTE, FN_LOAD, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h02, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
		{OP_BYTE, 8'hFF, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h4B, 1'b0, NO_BEAT},
		{OP_START, 8'h00, 1'b0, NO_BEAT},
		{OP_BYTE, FMT_RSP, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
		{OP_BYTE, FN_ENTRY, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
		{OP_BYTE, 8'h00, 1'b1, KIND_FAIL, 8'h00, 16'h0000, ERR_SUM, 1'b1}
	};

	network_boot_frame_client #(
		.ADDR_BITS(ADDR_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.slave_id_we(slave_id_we),
		.slave_id_wdata(slave_id_wdata),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic push_beat(input logic [2:0] k, input logic [7:0] d, input logic [15:0] a,
			input logic [2:0] e, input logic l);
		expected_beats.push_back({k, d, a, e, l});
	endtask

	task automatic push_request();
		logic [7:0] cks;
		cks = 8'h00 - (FMT_REQ + bc_slave_id);
		push_beat(KIND_TX, FMT_REQ, 16'h0000, ERR_NONE, 1'b0);
		push_beat(KIND_TX, 8'h00, 16'h0000, ERR_NONE, 1'b0);
		push_beat(KIND_TX, bc_slave_id, 16'h0000, ERR_NONE, 1'b0);
		push_beat(KIND_TX, 8'h00, 16'h0000, ERR_NONE, 1'b0);
		push_beat(KIND_TX, 8'h00, 16'h0000, ERR_NONE, 1'b0);
		push_beat(KIND_TX, cks, 16'h0000, ERR_NONE, 1'b1);
		bc_phase = PH_HEADER;
		hdr_pos = '0;
		pay_left = '0;
		pay_pos = '0;
		frame_sum = '0;
		fmt_seen = '0;
		func_seen = '0;
		arg_word = '0;
	endtask

	task automatic boot_client_predict(input item_t it, output bit active);
		logic [7:0] b;
		b = it.rx_byte;
		active = 1'b1;
		if (it.opcode == OP_START) begin
			load_addr = '0;
			push_request();
		end else if (it.opcode == OP_TIMEOUT && bc_phase != PH_IDLE) begin
			push_beat(KIND_FAIL, 8'h00, 16'h0000, ERR_TIMEOUT, 1'b1);
			bc_phase = PH_IDLE;
		end else if (it.opcode != OP_BYTE || bc_phase == PH_IDLE) begin
			active = 1'b0;
		end else begin
			frame_sum = frame_sum + b;
			case (bc_phase)
				PH_HEADER: begin
					if (hdr_pos == HDR_FORMAT)
						fmt_seen = b;
					else if (hdr_pos == HDR_FUNC)
						func_seen = b;
					else if (hdr_pos == HDR_SIZE)
						pay_left = b;
					if (hdr_pos >= HDR_SIZE) begin
						hdr_pos = '0;
						pay_pos = '0;
						bc_phase = (pay_left != 8'd0) ? PH_PAYLOAD : PH_CHECK;
					end else begin
						hdr_pos = hdr_pos + 3'd1;
					end
				end
				PH_PAYLOAD: begin
					if (pay_pos == 8'd0)
						arg_word[7:0] = b;
					else if (pay_pos == 8'd1)
						arg_word[15:8] = b;
					if (fmt_seen == FMT_RSP && func_seen == FN_PRINT) begin
						push_beat(KIND_CON, b, 16'h0000, ERR_NONE, 1'b1);
					end else if (fmt_seen == FMT_RSP && func_seen == FN_LOAD) begin
						push_beat(KIND_MEM, b, 16'(load_addr), ERR_NONE, 1'b1);
						load_addr = load_addr + {{(ADDR_BITS-1){1'b0}}, 1'b1};
					end
					pay_pos = pay_pos + 8'd1;
					pay_left = pay_left - 8'd1;
					if (pay_left == 8'd0)
						bc_phase = PH_CHECK;
				end
				default: begin
					bc_phase = PH_IDLE;
					if (frame_sum != 8'd0) begin
						push_beat(KIND_FAIL, 8'h00, 16'h0000, ERR_SUM, 1'b1);
					end else if (fmt_seen != FMT_RSP) begin
						push_beat(KIND_FAIL, 8'h00, 16'h0000, ERR_FORMAT, 1'b1);
					end else if (func_seen == FN_NAK) begin
						push_beat(KIND_FAIL, 8'h00, 16'h0000, ERR_NAK, 1'b1);
					end else if (func_seen > FN_ENTRY) begin
						push_beat(KIND_FAIL, 8'h00, 16'h0000, ERR_FUNC, 1'b1);
					end else if (func_seen == FN_ENTRY) begin
						push_beat(KIND_DONE, 8'h00, arg_word, ERR_NONE, 1'b1);
					end else begin
						if (func_seen == FN_ADDR)
							load_addr = arg_word;
						push_request();
					end
				end
			endcase
		end
	endtask

	task automatic send_item(input item_t it);
		int gap;
		bit active;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				item_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		boot_client_predict(it, active);
		if (active)
			live_items++;
	endtask

	task automatic send_frame();
		logic [7:0] frame_bytes[$];
		logic [7:0] fn;
		logic [7:0] siz;
		logic [7:0] sum;
		logic [7:0] b;
		int r;
		int cut;
		r = $urandom_range(0, 99);
		fn = (r < 30) ? FN_PRINT : (r < 55) ? FN_LOAD : (r < 72) ? FN_ADDR :
			(r < 85) ? FN_ENTRY : (r < 92) ? FN_NAK : 8'($urandom_range(5, 255));
		r = $urandom_range(0, 99);
		siz = (r < 88) ? 8'($urandom_range(0, 6)) : (r < 97) ? 8'($urandom_range(7, 40)) :
			8'($urandom_range(200, 255));
		frame_bytes.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) : FMT_RSP);
		frame_bytes.push_back(8'($urandom_range(0, 255)));
		frame_bytes.push_back(8'($urandom_range(0, 255)));
		frame_bytes.push_back(fn);
		frame_bytes.push_back(siz);
		for (int i = 0; i < siz; i++)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		sum = '0;
		foreach (frame_bytes[i])
			sum = sum + frame_bytes[i];
		b = 8'h00 - sum;
		if ($urandom_range(0, 11) == 0)
			b = b + 8'($urandom_range(1, 255));
		frame_bytes.push_back(b);
		cut = ($urandom_range(0, 15) == 0) ? $urandom_range(0, frame_bytes.size() - 1) : -1;
		for (int k = 0; k < frame_bytes.size(); k++) begin
			if (k == cut) begin
				if ($urandom_range(0, 1) == 1)
					send_item({OP_TIMEOUT, 8'($urandom_range(0, 255))});
				return;
			end
			send_item({OP_BYTE, frame_bytes[k]});
		end
	endtask

	// A boot session: request, then up to five response frames while the client keeps asking.
	task automatic run_session();
		int n_frames;
		send_item({OP_START, 8'($urandom_range(0, 255))});
		n_frames = $urandom_range(1, 5);
		for (int f = 0; f < n_frames; f++) begin
			send_frame();
			if (!(bc_phase == PH_HEADER && hdr_pos == 3'd0))
				break;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("beat with none expected", 32'(result), 32'(NO_BEAT));
			end else begin
				want = expected_beats.pop_front();
				if (result.kind !== want.kind)
					report_mismatch("kind", 32'(result.kind), 32'(want.kind));
				if (result.data_byte !== want.data_byte)
					report_mismatch("data_byte", 32'(result.data_byte), 32'(want.data_byte));
				if (result.address !== want.address)
					report_mismatch("address", 32'(result.address), 32'(want.address));
				if (result.error_code !== want.error_code)
					report_mismatch("error_code", 32'(result.error_code),
						32'(want.error_code));
				if (result.last !== want.last)
					report_mismatch("last", 32'(result.last), 32'(want.last));
			end
		end
	end

	initial begin
		int rx_cyc;
		int rx_mode;
		result_ready = 1'b0;
		rx_cyc = 0;
		rx_mode = RX_FREE;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off_req = 1'b0;
			end
			if (rx_cyc % 50 == 0)
				rx_mode = $urandom_range(RX_FREE, RX_SPARSE);
			rx_cyc++;
			case (rx_mode)
				RX_FREE: result_ready <= 1'b1;
				RX_COIN: result_ready <= 1'($urandom_range(0, 1));
				RX_PERIODIC: result_ready <= (rx_cyc % 7) >= 3;
				default: result_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	initial begin
		#5_000_000;
		$display("** network_boot_frame_client: FAILED **");
		$finish;
	end

	initial begin
		logic [7:0] sid;
		arst_n = 1'b0;
		slave_id_we = 1'b0;
		slave_id_wdata = 8'h00;
		item_valid = 1'b0;
		item = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_item(dir_rows[i].it);
			if (dir_rows[i].typed) begin
				void'(expected_beats.pop_back());
				expected_beats.push_back(dir_rows[i].want);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			sid = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(0, 255));
			@(negedge clk);
			item_valid <= 1'b0;
			while (expected_beats.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			@(negedge clk);
			slave_id_we <= 1'b1;
			slave_id_wdata <= sid;
			bc_slave_id = sid;
			@(negedge clk);
			slave_id_we <= 1'b0;
			if (ph == 1)
				hold_off_req = 1'b1;
			live_items = 0;
			while (live_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 8) begin
					run_session();
				end else begin
					repeat ($urandom_range(1, 4))
						send_item({2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))});
				end
			end
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** network_boot_frame_client: PASSED **");
		end else begin
			$display("** network_boot_frame_client: FAILED **");
		end
		$finish;
	end

endmodule
